[rtl/core/tch_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tch_pkg
// Types, register codes and the MSB-first CRC-32 lookup table shared by the
// table CRC-32 hash unit.
// ----------------------------------------------------------------------------
package tch_pkg;

	localparam int UNIT_W  = 16;
	localparam int HASH_W  = 32;
	localparam int BYTE_W  = 8;
	localparam int CFG_IDX_W = 2;

	localparam logic [HASH_W-1:0] CRC_POLY   = 32'h04C1_1DB7;
	localparam logic [HASH_W-1:0] LOW24_MASK = 32'h00FF_FFFF;

	// ASCII lower-case range and the bit that separates it from upper case.
	localparam logic [UNIT_W-1:0] CHAR_LOWER_A = 16'h0061;
	localparam logic [UNIT_W-1:0] CHAR_LOWER_Z = 16'h007A;
	localparam logic [UNIT_W-1:0] CHAR_CASE_BIT = 16'h0020;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_HASH_MODE = 2'd0,
		REG_CRC_SEED  = 2'd1
	} cfg_reg_t;

	typedef enum logic {
		MODE_BYTE_CRC = 1'b0,
		MODE_CHAR_HASH = 1'b1
	} hash_mode_t;

	typedef logic [HASH_W-1:0] crc_table_t [256];

	// Entry i is byte i placed in the top of the register and reduced over
	// eight left shifts. Evaluated once at elaboration.
	function automatic crc_table_t gen_crc_table();
		crc_table_t tbl;
		logic [HASH_W-1:0] v;
		for (int i = 0; i < 256; i++) begin
			v = {i[BYTE_W-1:0], 24'h000000};
			for (int k = 0; k < BYTE_W; k++) begin
				if (v[HASH_W-1]) begin
					v = (v << 1) ^ CRC_POLY;
				end else begin
					v = v << 1;
				end
			end
			tbl[i] = v;
		end
		return tbl;
	endfunction

	localparam crc_table_t CRC_TABLE = gen_crc_table();

endpackage

[rtl/core/tch_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tch_unit_if / tch_hash_if
// Valid/ready channels for message units and for finished hash values.
// ----------------------------------------------------------------------------
interface tch_unit_if;
	import tch_pkg::*;

	logic              valid;
	logic              ready;
	logic [UNIT_W-1:0] unit;
	logic              last_unit;

	modport source (output valid, output unit, output last_unit, input ready);
	modport sink   (input valid, input unit, input last_unit, output ready);
endinterface

interface tch_hash_if;
	import tch_pkg::*;

	logic              valid;
	logic              ready;
	logic [HASH_W-1:0] hash_value;

	modport source (output valid, output hash_value, input ready);
	modport sink   (input valid, input hash_value, output ready);
endinterface

[rtl/core/tch_update.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tch_update
// One unit's update of the running hash: a left table step on a byte in
// CRC mode, or two right table steps on an upper-cased character.
// ----------------------------------------------------------------------------
module tch_update (
	input  tch_pkg::hash_mode_t        mode,
	input  logic                       msg_start,
	input  logic [tch_pkg::HASH_W-1:0] seed,
	input  logic [tch_pkg::HASH_W-1:0] running,
	input  logic [tch_pkg::UNIT_W-1:0] unit,
	output logic [tch_pkg::HASH_W-1:0] next_hash
);
	import tch_pkg::*;

	logic [HASH_W-1:0] base;
	logic [UNIT_W-1:0] folded;
	logic [BYTE_W-1:0] idx_left;
	logic [BYTE_W-1:0] idx_lo;
	logic [BYTE_W-1:0] idx_hi;
	logic [HASH_W-1:0] left_hash;
	logic [HASH_W-1:0] mid_hash;
	logic [HASH_W-1:0] right_hash;

	always_comb begin
		if (msg_start) begin
			base = (mode == MODE_CHAR_HASH) ? '0 : ~seed;
		end else begin
			base = running;
		end

		if (unit >= CHAR_LOWER_A && unit <= CHAR_LOWER_Z) begin
			folded = unit & ~CHAR_CASE_BIT;
		end else begin
			folded = unit;
		end

		idx_left  = base[HASH_W-1 -: BYTE_W] ^ unit[BYTE_W-1:0];
		left_hash = (base << BYTE_W) ^ CRC_TABLE[idx_left];

		idx_lo   = base[BYTE_W-1:0] ^ folded[BYTE_W-1:0];
		mid_hash = ((base >> BYTE_W) & LOW24_MASK) ^ CRC_TABLE[idx_lo];
		idx_hi   = mid_hash[BYTE_W-1:0] ^ folded[UNIT_W-1 -: BYTE_W];
		right_hash = ((mid_hash >> BYTE_W) & LOW24_MASK) ^ CRC_TABLE[idx_hi];

		next_hash = (mode == MODE_CHAR_HASH) ? right_hash : left_hash;
	end

endmodule

[rtl/core/table_crc32_hash_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// table_crc32_hash_unit
// Streaming CRC-32 (MSB-first table, poly 0x04C11DB7) and case-insensitive
// 16-bit character hash, selected by the hash_mode register.
//
//   channel   dir   payload                    transfer
//   unit_ch   in    unit[15:0], last_unit      valid & ready
//   hash_ch   out   hash_value[31:0]           valid & ready
//   cfg_*     in    cfg_index[1:0], cfg_data   cfg_we
//
// One unit is taken per cycle unless a stalled result holds the input
// register. A unit is held in the input register and is folded into the
// running hash as it leaves; the hash of a message appears on hash_ch at
// the same edge at which its last unit leaves the input stage.
// The loop through the running-hash register (up to two chained table
// lookups) sets the single-cycle rate. A stalled result holds only units that
// end a message; other units keep flowing behind it.
// Reset clears the valid flags, the message flag and both registers.
// ----------------------------------------------------------------------------
module table_crc32_hash_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	tch_unit_if.sink                      unit_ch,
	tch_hash_if.source                    hash_ch,
	input  logic                          cfg_we,
	input  logic [tch_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [tch_pkg::HASH_W-1:0]    cfg_data
);
	import tch_pkg::*;

	hash_mode_t        hash_mode_q;
	logic [HASH_W-1:0] crc_seed_q;

	logic              valid_s1;
	logic [UNIT_W-1:0] unit_s1;
	logic              last_s1;

	logic [HASH_W-1:0] running_q;
	logic              in_msg_q;

	logic              out_valid_q;
	logic [HASH_W-1:0] out_hash_q;

	logic              advance_s1;
	logic              out_free;
	logic [HASH_W-1:0] next_hash;

	assign out_free   = !out_valid_q || hash_ch.ready;
	// A unit that ends a message needs room in the result register.
	assign advance_s1 = valid_s1 && (!last_s1 || out_free);
	assign unit_ch.ready = !valid_s1 || advance_s1;

	assign hash_ch.valid      = out_valid_q;
	assign hash_ch.hash_value = out_hash_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hash_mode_q <= MODE_BYTE_CRC;
			crc_seed_q  <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_HASH_MODE: hash_mode_q <= hash_mode_t'(cfg_data[0]);
				REG_CRC_SEED:  crc_seed_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	tch_update u_update (
		.mode      (hash_mode_q),
		.msg_start (!in_msg_q),
		.seed      (crc_seed_q),
		.running   (running_q),
		.unit      (unit_s1),
		.next_hash (next_hash)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			in_msg_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (unit_ch.ready) begin
				valid_s1 <= unit_ch.valid;
			end
			if (advance_s1) begin
				in_msg_q <= !last_s1;
			end
			if (advance_s1 && last_s1) begin
				out_valid_q <= 1'b1;
			end else if (hash_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (unit_ch.valid && unit_ch.ready) begin
			unit_s1 <= unit_ch.unit;
			last_s1 <= unit_ch.last_unit;
		end
		if (advance_s1) begin
			running_q <= next_hash;
		end
		if (advance_s1 && last_s1) begin
			out_hash_q <= (hash_mode_q == MODE_CHAR_HASH) ? next_hash : ~next_hash;
		end
	end

endmodule

[rtl/core/tch_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tch_checker
// Port-level checks of the hash unit: results only follow accepted last
// units, and at most two finished messages are ever held inside.
// ----------------------------------------------------------------------------
module tch_checker (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	input  logic                       in_ready,
	input  logic                       in_last,
	input  logic                       out_valid,
	input  logic                       out_ready,
	input  logic [tch_pkg::HASH_W-1:0] out_hash
);
	import tch_pkg::*;

	logic [1:0] pending_q;
	logic       in_end;
	logic       out_take;

	assign in_end   = in_valid && in_ready && in_last;
	assign out_take = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
		end else if (in_end && !out_take) begin
			pending_q <= pending_q + 2'd1;
		end else if (out_take && !in_end) begin
			pending_q <= pending_q - 2'd1;
		end
	end

	// A result is only shown for a message whose last unit was taken.
	a_no_orphan_result: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> pending_q != 2'd0)
		else $error("result shown without an accepted last unit");

	// The input and result registers hold at most two finished messages.
	a_capacity: assert property (@(posedge clk) disable iff (!arst_n)
		pending_q != 2'd3)
		else $error("more finished messages held than storage allows");

	// With two messages waiting and the result stalled, no further last unit is accepted.
	a_full_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(pending_q == 2'd2 && !out_ready) |-> !(in_valid && in_ready && in_last))
		else $error("last unit accepted with no room for its result");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(out_hash)))
		else $error("stalled result dropped or changed");

endmodule

bind table_crc32_hash_unit tch_checker u_tch_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (unit_ch.valid),
	.in_ready  (unit_ch.ready),
	.in_last   (unit_ch.last_unit),
	.out_valid (hash_ch.valid),
	.out_ready (hash_ch.ready),
	.out_hash  (hash_ch.hash_value)
);
